// ===== design/mcct_pkg.sv =====
// Shared constants, types and CRC7 helper functions for the MMC command CRC7 token block.
package mcct_pkg;

    localparam int CMD_W         = 7;
    localparam int ARG_W         = 32;
    localparam int FRAME_W       = CMD_W + ARG_W;     // 39 payload bits, top frame bit is zero
    localparam int CRC_REG_W     = 8;
    localparam int CRC_FIELD_W   = CRC_REG_W + 1;
    localparam int IDX_W         = 6;
    localparam int TABLE_SIZE    = 16;
    localparam int TABLE_IDX_W   = $clog2(TABLE_SIZE);
    localparam int CACHE_ENTRIES = 16;

    localparam int IN_TDATA_W    = ((FRAME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((CRC_FIELD_W + 7) / 8) * 8;

    localparam logic [CRC_REG_W-1:0] CRC_POLY  = 8'h09;
    localparam int                   START_BIT = CMD_W - 1;

    typedef logic [TABLE_SIZE-1:0][CRC_FIELD_W-1:0] t_cache_table;

    // Precomputed CRC fields for the common low command indices; zero means "not cached".
    localparam t_cache_table CACHE_TABLE = '{
        15: 9'h000, 14: 9'h000, 13: 9'h153, 12: 9'h000,
        11: 9'h000, 10: 9'h045,  9: 9'h0F1,  8: 9'h000,
         7: 9'h000,  6: 9'h000,  5: 9'h000,  4: 9'h000,
         3: 9'h17F,  2: 9'h04D,  1: 9'h143,  0: 9'h095
    };

    typedef struct packed {
        logic                   hit;
        logic [CRC_FIELD_W-1:0] field;
    } t_cache_rsp;

    typedef logic [FRAME_W-1:0][CRC_REG_W-1:0] t_crc_cols;

    // Bit-serial CRC register over a 40-bit frame, MSB first. Used at elaboration only.
    function automatic logic [CRC_REG_W-1:0] crc_reg_serial(input logic [FRAME_W:0] frame);
        logic [CRC_REG_W-1:0] r;
        r = '0;
        for (int b = FRAME_W; b >= 0; b--) begin
            r = {r[CRC_REG_W-2:0], 1'b0};
            if (frame[b] != r[CRC_REG_W-1]) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // The register starts at zero, so the CRC is linear in the frame bits:
    // one column per frame bit, XORed together where the bit is set.
    function automatic t_crc_cols crc_columns();
        t_crc_cols cols;
        for (int k = 0; k < FRAME_W; k++) begin
            cols[k] = crc_reg_serial((FRAME_W + 1)'(1) << k);
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_columns();

endpackage

// ===== design/mmc_command_crc7_token_core.sv =====
// Top level of the MMC command CRC7 token block: stream ports, pipeline and cache control.
//
// Takes one MMC command request (command byte plus 32-bit argument) per cycle
// while results drain, and returns the 9-bit CRC7-and-end-bit field that trails the frame.
// Two register stages: an input register, then the CRC XOR network and cache
// lookup, then the result register. A request in the input register moves on
// to the result register once that register is free. Both
// stages advance together whenever the result register is empty or being
// drained, so a stream sustains one request per cycle; a stalled result holds
// while the input register still takes one more request. When cache_enable is
// set (reset value) and the command byte has its start bit set with an index
// that has a nonzero entry in the fixed table, the table value is returned and
// from_cache is 1. Otherwise the CRC is computed over all 39 frame bits.
// Change cache_enable only while no request is in flight.
module mmc_command_crc7_token_core #(
    parameter int CACHE_ENTRIES = mcct_pkg::CACHE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,   // cache_enable
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [mcct_pkg::IN_TDATA_W-1:0]  i_s_tdata,       // [6:0] command_byte, [38:7] argument
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [mcct_pkg::OUT_TDATA_W-1:0] o_m_tdata,       // [8:0] crc_field
    output logic                             o_m_tuser        // [0] from_cache
);
    import mcct_pkg::*;

    logic                   r_cache_en;
    logic                   r_in_valid;
    logic [CMD_W-1:0]       r_cmd;
    logic [ARG_W-1:0]       r_arg;
    logic                   r_out_valid;
    logic [CRC_FIELD_W-1:0] r_crc_field;
    logic                   r_from_cache;

    logic                   out_free;
    logic                   in_accept;
    logic                   s2_load;
    logic [CRC_FIELD_W-1:0] calc_field;
    t_cache_rsp             cache_rsp;

    // Result register can take a new value when empty or being drained.
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign s2_load    = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_cache_en <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_s_tdata[CMD_W-1:0];
            r_arg <= i_s_tdata[CMD_W +: ARG_W];
        end
    end

    mcct_crc7 u_crc7 (
        .i_cmd_byte  (r_cmd),
        .i_argument  (r_arg),
        .o_crc_field (calc_field)
    );

    mcct_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_cache (
        .i_cmd_byte (r_cmd),
        .i_enable   (r_cache_en),
        .o_rsp      (cache_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_crc_field  <= cache_rsp.hit ? cache_rsp.field : calc_field;
            r_from_cache <= cache_rsp.hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_crc_field);
    assign o_m_tuser  = r_from_cache;

    // Every delivered field carries the end bit, cached or computed.
    a_end_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[0])
        else $error("crc field without end bit");

    // An accepted request lands in the input register.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted request lost at input register");

    // A request leaving the input register shows up as a result.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> o_m_tvalid)
        else $error("request lost between stages");

endmodule

// ===== design/mcct_crc7.sv =====
// XOR network that gives the CRC7 field of one command frame.
module mcct_crc7 (
    input  logic [mcct_pkg::CMD_W-1:0]       i_cmd_byte,
    input  logic [mcct_pkg::ARG_W-1:0]       i_argument,
    output logic [mcct_pkg::CRC_FIELD_W-1:0] o_crc_field
);
    import mcct_pkg::*;

    logic [FRAME_W-1:0]   frame;
    logic [CRC_REG_W-1:0] crc_reg;

    assign frame = {i_cmd_byte, i_argument};

    always_comb begin
        crc_reg = '0;
        for (int k = 0; k < FRAME_W; k++) begin
            if (frame[k]) begin
                crc_reg = crc_reg ^ CRC_COLS[k];
            end
        end
    end

    // end bit in bit 0
    assign o_crc_field = {crc_reg, 1'b1};

endmodule

// ===== design/mcct_cache.sv =====
// Lookup of precomputed CRC fields for low command indices.
module mcct_cache #(
    parameter int CACHE_ENTRIES = mcct_pkg::CACHE_ENTRIES
) (
    input  logic [mcct_pkg::CMD_W-1:0] i_cmd_byte,
    input  logic                       i_enable,
    output mcct_pkg::t_cache_rsp       o_rsp
);
    import mcct_pkg::*;

    logic [IDX_W-1:0]       idx;
    logic                   in_range;
    logic [CRC_FIELD_W-1:0] entry;

    assign idx      = i_cmd_byte[IDX_W-1:0];
    assign in_range = (int'(idx) < CACHE_ENTRIES) && (int'(idx) < TABLE_SIZE);
    assign entry    = in_range ? CACHE_TABLE[idx[TABLE_IDX_W-1:0]] : '0;

    assign o_rsp.hit   = i_enable && i_cmd_byte[START_BIT] && in_range && (entry != '0);
    assign o_rsp.field = entry;

endmodule
